// ===== hw/rtl/mcr_pkg.sv =====
// mcr_pkg: shared constants for the midpoint circle rasterizer
// octant mirror tables, action codes and queue sizing; no dependencies

package mcr_pkg;

  // input action codes
  localparam logic ACT_START = 1'b0;
  localparam logic ACT_STEP  = 1'b1;

  // pixels per step, one per mirror octant
  localparam int unsigned OCT_COUNT = 8;
  localparam int unsigned OCT_BITS  = 3;
  localparam logic [OCT_BITS-1:0] OCT_FIRST = 3'd0;
  localparam logic [OCT_BITS-1:0] OCT_LAST  = 3'd7;

  // per-octant mirror controls, bit k serves octant k
  // order: (x,y) (y,x) (-x,y) (-y,x) (-x,-y) (-y,-x) (x,-y) (y,-x)
  localparam logic [OCT_COUNT-1:0] OCT_SWAP  = 8'b1010_1010;
  localparam logic [OCT_COUNT-1:0] OCT_NEG_A = 8'b0011_1100;
  localparam logic [OCT_COUNT-1:0] OCT_NEG_B = 8'b1111_0000;

  // step queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

endpackage

// ===== hw/rtl/mcr_if.sv =====
// mcr_in_if / mcr_out_if: valid/ready channels of the circle rasterizer
// request channel (start or step) and pixel channel; no dependencies

interface mcr_in_if #(
  parameter int unsigned COORD_BITS = 10
) ();
  logic                  valid;
  logic                  ready;
  logic                  action;
  logic [COORD_BITS-1:0] center_x;
  logic [COORD_BITS-1:0] center_y;
  logic [COORD_BITS-1:0] radius;

  modport source (output valid, action, center_x, center_y, radius, input ready);
  modport sink   (input valid, action, center_x, center_y, radius, output ready);
endinterface

interface mcr_out_if #(
  parameter int unsigned COORD_BITS = 10
) ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS+1:0] pixel_x;
  logic signed [COORD_BITS+1:0] pixel_y;
  logic [2:0]                   octant;
  logic                         last_of_step;
  logic                         circle_done;

  modport source (output valid, pixel_x, pixel_y, octant, last_of_step, circle_done,
                  input ready);
  modport sink   (input valid, pixel_x, pixel_y, octant, last_of_step, circle_done,
                  output ready);
endinterface

// ===== hw/rtl/midpoint_circle_rasterizer_core.sv =====
// midpoint_circle_rasterizer_core: top level of the midpoint circle rasterizer
// front (state update), step queue and back (pixel expansion); uses mcr_pkg, mcr_if
//
// channel  dir  handshake      payload
// req      in   valid/ready    action, center_x, center_y, radius
// pix      out  valid/ready    pixel_x, pixel_y, octant, last_of_step, circle_done
//
// a step that draws gives eight pixels, one per cycle unless pix.ready stalls the back;
// the step rate is set by the single pixel port of the back part
// start items and steps while idle yield nothing
// the front keeps taking requests while the step queue has room; the back stalls
// only on pix.ready, the front only on a full queue
// synchronous reset clears the drawing state, the queue and the output valid

module midpoint_circle_rasterizer_core #(
  parameter int unsigned COORD_BITS = 10
) (
  input  logic clk,
  input  logic rst,
  mcr_in_if.sink    req,
  mcr_out_if.source pix
);

  localparam int unsigned ENTRY_BITS = 4 * COORD_BITS + 3;

  logic                  q_push;
  logic [ENTRY_BITS-1:0] q_data;
  logic                  q_full;
  logic                  q_pop;
  logic                  q_empty;
  logic [ENTRY_BITS-1:0] q_head;

  // request handling and midpoint state
  mcr_front #(
    .COORD_BITS (COORD_BITS),
    .ENTRY_BITS (ENTRY_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .action   (req.action),
    .center_x (req.center_x),
    .center_y (req.center_y),
    .radius   (req.radius),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_data)
  );

  // step queue
  mcr_queue #(
    .ENTRY_BITS (ENTRY_BITS)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_data),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  // pixel expansion
  mcr_back #(
    .COORD_BITS (COORD_BITS),
    .ENTRY_BITS (ENTRY_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .out_valid    (pix.valid),
    .out_ready    (pix.ready),
    .pixel_x      (pix.pixel_x),
    .pixel_y      (pix.pixel_y),
    .octant       (pix.octant),
    .last_of_step (pix.last_of_step),
    .circle_done  (pix.circle_done)
  );

endmodule

// ===== hw/rtl/mcr_front.sv =====
// mcr_front: takes start/step requests and advances the midpoint state
// pushes one queue entry per drawing step; uses mcr_pkg

module mcr_front #(
  parameter int unsigned COORD_BITS = 10,
  parameter int unsigned ENTRY_BITS = 4 * COORD_BITS + 3
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  action,
  input  logic [COORD_BITS-1:0] center_x,
  input  logic [COORD_BITS-1:0] center_y,
  input  logic [COORD_BITS-1:0] radius,
  input  logic                  q_full,
  output logic                  q_push,
  output logic [ENTRY_BITS-1:0] q_data
);

  localparam int unsigned OW = COORD_BITS + 1;
  localparam int unsigned DW = COORD_BITS + 4;

  // drawing state
  logic [COORD_BITS-1:0] held_x;
  logic [COORD_BITS-1:0] held_y;
  logic [OW-1:0]         offset_major;
  logic [OW-1:0]         offset_minor;
  logic [DW-1:0]         decision_term;
  logic                  active;

  logic          accept;
  logic [OW-1:0] major_next;
  logic [OW-1:0] minor_next;
  logic [DW-1:0] decision_next;
  logic          done;
  logic [DW-1:0] minor_w;
  logic [DW-1:0] major_w;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // next offset pair and decision term
  always_comb begin
    minor_next = offset_minor + OW'(1);
    minor_w    = DW'(minor_next);
    if (decision_term[DW-1]) begin
      major_next    = offset_major;
      major_w       = DW'(offset_major);
      decision_next = decision_term + (minor_w << 1) + DW'(1);
    end else begin
      major_next    = offset_major - OW'(1);
      major_w       = DW'(major_next);
      decision_next = decision_term + ((minor_w - major_w + DW'(1)) << 1);
    end
    // signed compare, the major offset drops to -1 on a zero radius
    done = ($signed(major_next) < $signed(minor_next));
  end

  // queue entry carries the current pair, so the back needs no midpoint state of its own
  assign q_push = accept && (action == mcr_pkg::ACT_STEP) && active;
  assign q_data = {held_x, held_y, offset_major, offset_minor, done};

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (accept) begin
      if (action == mcr_pkg::ACT_START) begin
        active <= 1'b1;
      end else if (active && done) begin
        active <= 1'b0;
      end
    end
  end

  // offsets, decision term and center
  always_ff @(posedge clk) begin
    if (rst) begin
      offset_major  <= '0;
      offset_minor  <= '0;
      decision_term <= '0;
      held_x        <= '0;
      held_y        <= '0;
    end else if (accept) begin
      if (action == mcr_pkg::ACT_START) begin
        held_x        <= center_x;
        held_y        <= center_y;
        offset_major  <= OW'(radius);
        offset_minor  <= '0;
        decision_term <= DW'(1) - DW'(radius);
      end else if (active) begin
        offset_major  <= major_next;
        offset_minor  <= minor_next;
        decision_term <= decision_next;
      end
    end
  end

endmodule

// ===== hw/rtl/mcr_queue.sv =====
// mcr_queue: short register queue of step entries between front and back
// depth from mcr_pkg; uses mcr_pkg

module mcr_queue #(
  parameter int unsigned ENTRY_BITS = 43
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  logic [ENTRY_BITS-1:0] push_data,
  output logic                  full,
  input  logic                  pop,
  output logic                  empty,
  output logic [ENTRY_BITS-1:0] head
);

  localparam int unsigned DEPTH = mcr_pkg::QUEUE_DEPTH;
  localparam int unsigned PW    = mcr_pkg::QPTR_BITS;
  localparam int unsigned CW    = mcr_pkg::QCNT_BITS;

  logic [ENTRY_BITS-1:0] slots [DEPTH];
  logic [PW-1:0]         wr_ptr;
  logic [PW-1:0]         rd_ptr;
  logic [CW-1:0]         count;
  logic                  do_push;
  logic                  do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

// ===== hw/rtl/mcr_back.sv =====
// mcr_back: expands one queued step into eight mirrored pixels
// one pixel per cycle while out_ready does not stall, into an output register; uses mcr_pkg

module mcr_back #(
  parameter int unsigned COORD_BITS = 10,
  parameter int unsigned ENTRY_BITS = 4 * COORD_BITS + 3
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_empty,
  input  logic [ENTRY_BITS-1:0]        q_head,
  output logic                         q_pop,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [COORD_BITS+1:0] pixel_x,
  output logic signed [COORD_BITS+1:0] pixel_y,
  output logic [2:0]                   octant,
  output logic                         last_of_step,
  output logic                         circle_done
);

  localparam int unsigned OW = COORD_BITS + 1;
  localparam int unsigned PW = COORD_BITS + 2;

  logic [COORD_BITS-1:0]        cx;
  logic [COORD_BITS-1:0]        cy;
  logic [OW-1:0]                ox;
  logic [OW-1:0]                oy;
  logic                         step_done;
  logic [mcr_pkg::OCT_BITS-1:0] oct;
  logic                         advance;
  logic                         load;
  logic [OW-1:0]                off_a;
  logic [OW-1:0]                off_b;
  logic [PW-1:0]                px;
  logic [PW-1:0]                py;

  assign {cx, cy, ox, oy, step_done} = q_head;

  assign advance = !out_valid || out_ready;
  assign load    = advance && !q_empty;
  assign q_pop   = load && (oct == mcr_pkg::OCT_LAST);

  // mirror the offset pair for the current octant
  always_comb begin
    off_a = mcr_pkg::OCT_SWAP[oct] ? oy : ox;
    off_b = mcr_pkg::OCT_SWAP[oct] ? ox : oy;
    px = mcr_pkg::OCT_NEG_A[oct] ? PW'(cx) - PW'(off_a) : PW'(cx) + PW'(off_a);
    py = mcr_pkg::OCT_NEG_B[oct] ? PW'(cy) - PW'(off_b) : PW'(cy) + PW'(off_b);
  end

  // octant counter and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      oct       <= mcr_pkg::OCT_FIRST;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        oct <= oct + 3'd1;
      end
      if (advance) begin
        out_valid <= load;
      end
    end
  end

  // output payload register
  always_ff @(posedge clk) begin
    if (load) begin
      pixel_x      <= $signed(px);
      pixel_y      <= $signed(py);
      octant       <= oct;
      last_of_step <= (oct == mcr_pkg::OCT_LAST);
      circle_done  <= (oct == mcr_pkg::OCT_LAST) && step_done;
    end
  end

endmodule

// ===== tb/tb_midpoint_circle_rasterizer_core.sv =====
// tb_midpoint_circle_rasterizer_core: self-checking testbench for the circle rasterizer
// predicts every pixel of each step and checks the pixel channel in order
// depends on mcr_pkg, mcr_if and midpoint_circle_rasterizer_core

module tb_midpoint_circle_rasterizer_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CB = 10;
  localparam int unsigned OB = CB + 2;
  localparam int unsigned XB = CB + 1;
  localparam int unsigned DB = CB + 4;
  localparam int unsigned OCTB = mcr_pkg::OCT_BITS;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic signed [OB-1:0] px;
    logic signed [OB-1:0] py;
    logic [OCTB-1:0]      oct;
    logic                 last;
    logic                 done;
  } pixel_t;

  logic clk;
  logic rst;

  mcr_in_if  #(.COORD_BITS(CB)) req_if ();
  mcr_out_if #(.COORD_BITS(CB)) pix_if ();

  midpoint_circle_rasterizer_core #(.COORD_BITS(CB)) u_top (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .pix (pix_if)
  );

  // mirrored circle state, reset values
  logic [CB-1:0]        ctr_x    = '0;
  logic [CB-1:0]        ctr_y    = '0;
  logic [CB:0]          off_x    = '0;
  logic [CB:0]          off_y    = '0;
  logic signed [CB+3:0] dec_term = '0;
  logic                 drawing  = 1'b0;

  pixel_t pending_pixels[$];

  int mismatch_count = 0;
  int drawing_items  = 0;
  int cycle_count    = 0;
  int hold_left      = 0;
  int src_idle_pct   = 0;
  int dst_idle_pct   = 0;

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // cycle counter and timeout
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_midpoint_circle_rasterizer_core NOT OK");
    $finish;
  end

  // pixel receiver: random stalls, plus a long hold-off when requested
  initial begin
    pix_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        pix_if.ready <= 1'b0;
        hold_left--;
      end else begin
        pix_if.ready <= ($urandom_range(0, 99) >= dst_idle_pct);
      end
    end
  end

  function automatic void note_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%s", msg);
  endfunction

  // expected pixels of one request; advances the mirrored circle state
  function automatic void plot_request(logic act, logic [CB-1:0] cx, logic [CB-1:0] cy,
                                       logic [CB-1:0] r);
    int     x, y, d, a, b, k;
    logic   fin;
    logic   neg_a, neg_b;
    pixel_t p;
    if (act == mcr_pkg::ACT_START) begin
      ctr_x    = cx;
      ctr_y    = cy;
      off_x    = {1'b0, r};
      off_y    = '0;
      dec_term = DB'(1 - int'(r));
      drawing  = 1'b1;
      return;
    end
    if (!drawing) return;

    // next offset pair
    x = int'(off_x);
    y = int'(off_y) + 1;
    d = int'(dec_term);
    if (d < 0) begin
      d += 2 * y + 1;
    end else begin
      x -= 1;
      d += 2 * (y - x + 1);
    end
    fin = (x < y);

    // eight mirrored pixels of the current pair
    for (k = 0; k < mcr_pkg::OCT_COUNT; k++) begin
      a = (k % 2) ? int'(off_y) : int'(off_x);
      b = (k % 2) ? int'(off_x) : int'(off_y);
      neg_a = (k >= 2 && k <= 5);
      neg_b = (k >= 4);
      p.px   = OB'(int'(ctr_x) + (neg_a ? -a : a));
      p.py   = OB'(int'(ctr_y) + (neg_b ? -b : b));
      p.oct  = OCTB'(k);
      p.last = (k == mcr_pkg::OCT_COUNT - 1);
      p.done = p.last && fin;
      pending_pixels.push_back(p);
    end

    off_x    = XB'(x);
    off_y    = XB'(y);
    dec_term = DB'(d);
    if (fin) drawing = 1'b0;
  endfunction

  // pixel checker: a transaction is taken at the edge after the sample
  initial begin
    pixel_t got, want;
    forever begin
      @(negedge clk);
      if (!rst && pix_if.valid && pix_if.ready) begin
        got.px   = pix_if.pixel_x;
        got.py   = pix_if.pixel_y;
        got.oct  = pix_if.octant;
        got.last = pix_if.last_of_step;
        got.done = pix_if.circle_done;
        if (pending_pixels.size() == 0) begin
          note_mismatch($sformatf("unexpected pixel x=%0d y=%0d oct=%0d last=%0b done=%0b",
                                  got.px, got.py, got.oct, got.last, got.done));
        end else begin
          want = pending_pixels.pop_front();
          if (got.px !== want.px || got.py !== want.py || got.oct !== want.oct ||
              got.last !== want.last || got.done !== want.done) begin
            note_mismatch({
              $sformatf("pixel mismatch: expected x=%0d y=%0d oct=%0d last=%0b done=%0b",
                        want.px, want.py, want.oct, want.last, want.done),
              $sformatf(", got x=%0d y=%0d oct=%0d last=%0b done=%0b",
                        got.px, got.py, got.oct, got.last, got.done)});
          end
        end
      end
    end
  end

  // send one request transaction; called and returns at a rising edge
  task automatic send_req(input logic act, input logic [CB-1:0] cx, input logic [CB-1:0] cy,
                          input logic [CB-1:0] r);
    logic took;
    if (act == mcr_pkg::ACT_START || drawing) drawing_items++;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid    <= 1'b1;
    req_if.action   <= act;
    req_if.center_x <= cx;
    req_if.center_y <= cy;
    req_if.radius   <= r;
    do begin
      @(negedge clk);
      took = req_if.valid && req_if.ready;
      @(posedge clk);
    end while (!took);
    plot_request(act, cx, cy, r);
  endtask

  // start a circle and step it until done or max_steps, step fields are junk
  task automatic run_circle(input logic [CB-1:0] cx, input logic [CB-1:0] cy,
                            input logic [CB-1:0] r, input int max_steps);
    int n;
    n = 0;
    send_req(mcr_pkg::ACT_START, cx, cy, r);
    while (drawing && n < max_steps) begin
      send_req(mcr_pkg::ACT_STEP, CB'($urandom), CB'($urandom), CB'($urandom));
      n++;
    end
  endtask

  // step right after reset is ignored
  task automatic test_idle_step();
    send_req(mcr_pkg::ACT_STEP, '1, '1, '1);
  endtask

  // zero radius: one step of eight center pixels, then an ignored step
  task automatic test_zero_radius();
    run_circle('0, '0, '0, 4);
    send_req(mcr_pkg::ACT_STEP, '0, '0, '0);
  endtask

  // field extremes, abandoned circles and back-to-back starts
  task automatic test_extreme_fields();
    run_circle('1, '1, '1, 2);
    run_circle('0, '0, '1, 2);
    send_req(mcr_pkg::ACT_START, '0, '1, CB'(1));
    run_circle(CB'(512), CB'(512), CB'(1), 4);
    send_req(mcr_pkg::ACT_STEP, '1, '0, '1);
  endtask

  // small circles drawn to completion
  task automatic test_small_circles();
    run_circle('0, '1, CB'(2), 4);
    run_circle(CB'(300), CB'(700), CB'(5), 10);
  endtask

  // mostly well-formed circles with random content, some noise
  task automatic test_random_traffic(input int n_items);
    int target;
    target = drawing_items + n_items;
    while (drawing_items < target) begin
      case ($urandom_range(0, 9))
        0: send_req(1'($urandom_range(0, 1)), CB'($urandom), CB'($urandom), CB'($urandom));
        1: run_circle(CB'($urandom), CB'($urandom), CB'($urandom), $urandom_range(1, 6));
        default: begin
          run_circle(CB'($urandom), CB'($urandom), CB'($urandom_range(0, 24)),
                     ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : 1000);
          if ($urandom_range(0, 3) == 0)
            send_req(mcr_pkg::ACT_STEP, CB'($urandom), CB'($urandom), CB'($urandom));
        end
      endcase
    end
  endtask

  // receiver holds off while steps keep coming, so the step queue fills
  task automatic test_pressure();
    req_if.valid <= 1'b0;
    @(negedge clk);
    hold_left = HOLD_CYCLES;
    @(posedge clk);
    run_circle(CB'(100), CB'(900), CB'(200), 40);
  endtask

  // stimulus
  initial begin
    int n;
    rst             <= 1'b1;
    req_if.valid    <= 1'b0;
    req_if.action   <= mcr_pkg::ACT_STEP;
    req_if.center_x <= '0;
    req_if.center_y <= '0;
    req_if.radius   <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    src_idle_pct = 25;
    dst_idle_pct = 51;
    test_idle_step();
    test_zero_radius();
    test_extreme_fields();
    test_small_circles();
    test_random_traffic(85);

    src_idle_pct = 51;
    dst_idle_pct = 25;
    test_random_traffic(85);

    src_idle_pct = 0;
    dst_idle_pct = 0;
    test_pressure();
    test_random_traffic(85);

    // drain outstanding pixels, then let the pipeline settle
    req_if.valid <= 1'b0;
    n = 0;
    while (pending_pixels.size() > 0 && n < DRAIN_LIMIT) begin
      @(posedge clk);
      n++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_pixels.size() != 0)
      note_mismatch($sformatf("%0d expected pixels never arrived", pending_pixels.size()));

    if (mismatch_count == 0) begin
      $display("tb_midpoint_circle_rasterizer_core OK");
    end else begin
      $display("tb_midpoint_circle_rasterizer_core NOT OK");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/mcr_pkg.sv
hw/rtl/mcr_if.sv
hw/rtl/mcr_front.sv
hw/rtl/mcr_queue.sv
hw/rtl/mcr_back.sv
hw/rtl/midpoint_circle_rasterizer_core.sv
tb/tb_midpoint_circle_rasterizer_core.sv
